### rtl/min_max_counting_priority_queue_defines.svh
// Assertion macros for the queue RTL.
`ifndef MIN_MAX_COUNTING_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_MAX_COUNTING_PRIORITY_QUEUE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MMCPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define MMCPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mmcpq_pkg.sv
package mmcpq_pkg;

  localparam int unsigned KEY_W      = 10;
  localparam int unsigned TOTAL_W    = 24;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned WORD_BIT_W = 5;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_SET_MODE = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  // Mode select codes
  localparam logic [1:0] SEL_LEAST    = 2'd1;
  localparam logic [1:0] SEL_GREATEST = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [1:0]       mode_select;
  } mmcpq_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] removed_key;
    logic             was_empty;
  } mmcpq_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic dispatch_read;
    logic mark_empty;
    logic set_mode;
    logic clear_state;
    logic clr_write;
    logic add_commit;
    logic rem_commit;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } mmcpq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic key_ok;
    logic total_zero;
    logic total_one;
    logic rem_zero;
    logic scan_hit;
    logic clr_last;
    logic out_free;
  } mmcpq_status_t;

  // Index of the lowest set bit of a bitmap word
  function automatic logic [WORD_BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [WORD_BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) idx = WORD_BIT_W'(i);
    end
    return idx;
  endfunction

  // Index of the highest set bit of a bitmap word
  function automatic logic [WORD_BIT_W-1:0] highest_set(input logic [WORD_BITS-1:0] w);
    logic [WORD_BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) idx = WORD_BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

### rtl/mmcpq_ctrl.sv
module mmcpq_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  mmcpq_pkg::mmcpq_status_t status_i,
  output mmcpq_pkg::mmcpq_cmd_t    cmd_o
);
  import mmcpq_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_ADD,
    S_REMOVE,
    S_SCAN_START,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.op)
          OP_ADD: begin
            if (status_i.key_ok) begin
              cmd_o.dispatch_read = 1'b1;
              state_d             = S_ADD;
            end else begin
              state_d = S_IDLE;
            end
          end
          OP_REMOVE: begin
            if (status_i.total_zero) begin
              cmd_o.mark_empty = 1'b1;
              state_d          = S_RESULT;
            end else begin
              cmd_o.dispatch_read = 1'b1;
              state_d             = S_REMOVE;
            end
          end
          OP_SET_MODE: begin
            cmd_o.set_mode = 1'b1;
            state_d        = S_IDLE;
          end
          OP_CLEAR: begin
            cmd_o.clear_state = 1'b1;
            state_d           = S_CLEAR;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_ADD: begin
        cmd_o.add_commit = 1'b1;
        state_d          = S_IDLE;
      end
      S_REMOVE: begin
        cmd_o.rem_commit = 1'b1;
        // last entry gone: bounds no longer matter
        if (status_i.total_one)     state_d = S_RESULT;
        else if (status_i.rem_zero) state_d = S_SCAN_START;
        else                        state_d = S_RESULT;
      end
      S_SCAN_START: begin
        cmd_o.scan_start = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_hit) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/mmcpq_dp.sv
module mmcpq_dp #(
  parameter int unsigned KEYS       = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mmcpq_pkg::mmcpq_in_t     in_data_i,
  input  logic                     out_ready_i,
  input  mmcpq_pkg::mmcpq_cmd_t    cmd_i,
  output mmcpq_pkg::mmcpq_status_t status_o,
  output logic                     out_valid_o,
  output mmcpq_pkg::mmcpq_out_t    out_data_o
);
  import mmcpq_pkg::*;

  localparam int unsigned KAW   = $clog2(KEYS);
  localparam int unsigned WORDS = (KEYS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

  // Count store; an entry is meaningful only where its bitmap bit is set
  logic [COUNT_BITS-1:0] cnt_mem [KEYS];
  logic [COUNT_BITS-1:0] cnt_rdata_q;
  // Occupancy bitmap, one bit per key
  logic [WORD_BITS-1:0]  bm_mem [WORDS];
  logic [WORD_BITS-1:0]  bm_rdata_q;

  mmcpq_in_t             item_q;
  mmcpq_out_t            out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic [KAW-1:0]        least_q, least_d, greatest_q, greatest_d;
  logic [KAW-1:0]        pick_q, pick_sel, key_idx;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic                  mode_q, mode_d;
  logic                  empty_q, empty_d;
  logic [WAW-1:0]        clr_addr_q, clr_addr_d;
  logic [WAW-1:0]        scan_addr_q, scan_addr_d;
  logic [WAW-1:0]        pick_word, sel_word, bm_raddr, bm_waddr;
  logic [WORD_BIT_W-1:0] pick_bit;
  logic [WORD_BITS-1:0]  pick_mask, bm_wdata;
  logic [COUNT_BITS-1:0] cnt_eff, cnt_new, cnt_wdata;
  logic                  key_ok, add_ok, out_free, scan_hit;
  logic                  cnt_we, bm_we, bm_rd_en;

  // Key and pick decode
  assign key_idx   = KAW'(item_q.key);
  assign key_ok    = (32'(item_q.key) < 32'(KEYS));
  assign pick_sel  = (op_e'(item_q.op) == OP_ADD) ? key_idx
                   : (mode_q ? greatest_q : least_q);
  assign sel_word  = WAW'(pick_sel >> WORD_BIT_W);
  assign pick_word = WAW'(pick_q >> WORD_BIT_W);
  assign pick_bit  = WORD_BIT_W'(pick_q);
  assign pick_mask = WORD_BITS'(1) << pick_bit;

  // Effective count and its updates
  assign cnt_eff  = bm_rdata_q[pick_bit] ? cnt_rdata_q : '0;
  assign cnt_new  = (cnt_eff == '0) ? '0 : cnt_eff - COUNT_BITS'(1);
  assign add_ok   = (cnt_eff != '1) && (total_q != '1);
  assign scan_hit = |bm_rdata_q;
  assign out_free = !out_valid_q || out_ready_i;

  // Memory port control
  assign cnt_we    = (cmd_i.add_commit && add_ok) || cmd_i.rem_commit;
  assign cnt_wdata = cmd_i.add_commit ? cnt_eff + COUNT_BITS'(1) : cnt_new;
  assign bm_we     = cmd_i.clr_write || (cmd_i.add_commit && add_ok)
                   || (cmd_i.rem_commit && (cnt_new == '0));
  assign bm_waddr  = cmd_i.clr_write ? clr_addr_q : pick_word;
  assign bm_wdata  = cmd_i.clr_write  ? '0
                   : cmd_i.add_commit ? (bm_rdata_q | pick_mask)
                   : (bm_rdata_q & ~pick_mask);
  assign bm_rd_en  = cmd_i.dispatch_read || cmd_i.scan_start || cmd_i.scan_step;
  assign bm_raddr  = cmd_i.dispatch_read ? sel_word
                   : cmd_i.scan_start ? pick_word : scan_addr_d;

  // Bitmap walk: upward for least mode, downward for greatest mode
  always_comb begin
    scan_addr_d = scan_addr_q;
    if (cmd_i.scan_start) begin
      scan_addr_d = pick_word;
    end else if (cmd_i.scan_step && !scan_hit) begin
      scan_addr_d = mode_q ? scan_addr_q - WAW'(1) : scan_addr_q + WAW'(1);
    end
  end

  // Queue state update
  always_comb begin
    least_d     = least_q;
    greatest_d  = greatest_q;
    total_d     = total_q;
    mode_d      = mode_q;
    empty_d     = empty_q;
    clr_addr_d  = clr_addr_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.clear_state) begin
      total_d    = '0;
      mode_d     = 1'b0;
      clr_addr_d = '0;
    end
    if (cmd_i.clr_write) clr_addr_d = clr_addr_q + WAW'(1);
    if (cmd_i.set_mode) begin
      if (item_q.mode_select == SEL_LEAST)         mode_d = 1'b0;
      else if (item_q.mode_select == SEL_GREATEST) mode_d = 1'b1;
    end
    if (cmd_i.mark_empty)    empty_d = 1'b1;
    if (cmd_i.dispatch_read) empty_d = 1'b0;
    if (cmd_i.add_commit && add_ok) begin
      total_d = total_q + TOTAL_W'(1);
      if (total_q == '0) begin
        least_d    = pick_q;
        greatest_d = pick_q;
      end else begin
        if (pick_q < least_q)    least_d    = pick_q;
        if (pick_q > greatest_q) greatest_d = pick_q;
      end
    end
    if (cmd_i.rem_commit) total_d = total_q - TOTAL_W'(1);
    if (cmd_i.scan_step && scan_hit) begin
      if (mode_q) greatest_d = KAW'({scan_addr_q, highest_set(bm_rdata_q)});
      else        least_d    = KAW'({scan_addr_q, lowest_set(bm_rdata_q)});
    end
    // output register
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.load_out) begin
      out_valid_d       = 1'b1;
      out_d.removed_key = empty_q ? '0 : KEY_W'(pick_q);
      out_d.was_empty   = empty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      least_q     <= '0;
      greatest_q  <= '0;
      total_q     <= '0;
      mode_q      <= 1'b0;
      empty_q     <= 1'b0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      least_q     <= least_d;
      greatest_q  <= greatest_d;
      total_q     <= total_d;
      mode_q      <= mode_d;
      empty_q     <= empty_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture)       item_q <= in_data_i;
    if (cmd_i.dispatch_read) pick_q <= pick_sel;
    scan_addr_q <= scan_addr_d;
    out_q       <= out_d;
  end

  // Count store
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[pick_q] <= cnt_wdata;
    if (cmd_i.dispatch_read) cnt_rdata_q <= cnt_mem[pick_sel];
  end

  // Occupancy bitmap
  always_ff @(posedge clk_i) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    if (bm_rd_en) bm_rdata_q <= bm_mem[bm_raddr];
  end

  assign status_o.op         = op_e'(item_q.op);
  assign status_o.key_ok     = key_ok;
  assign status_o.total_zero = (total_q == '0);
  assign status_o.total_one  = (total_q == TOTAL_W'(1));
  assign status_o.rem_zero   = (cnt_new == '0);
  assign status_o.scan_hit   = scan_hit;
  assign status_o.clr_last   = (clr_addr_q == WAW'(WORDS - 1));
  assign status_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/min_max_counting_priority_queue.sv
// One transaction at a time. Add: dispatch, then commit; set mode: dispatch only.
// Remove: dispatch, commit, then result (straight from dispatch on an empty queue); when
// a key runs out with entries left, the 32-bit occupancy words are walked first.
// The result loads once the output is free. Clear: one bitmap word zeroed per cycle.
// Reset: asynchronous, active low; after release a clearing pass over all ceil(KEYS/32)
// bitmap words (32 at the default size) runs before the first transaction is taken.
`include "min_max_counting_priority_queue_defines.svh"

module min_max_counting_priority_queue #(
  parameter int unsigned KEYS       = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mmcpq_pkg::mmcpq_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mmcpq_pkg::mmcpq_out_t out_data_o
);
  import mmcpq_pkg::*;

  mmcpq_cmd_t    cmd;
  mmcpq_status_t status;

  mmcpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mmcpq_dp #(
    .KEYS       (KEYS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // A pending result is never overwritten
  `MMCPQ_ASSERT_NOW(a_load_free, clk_i, rst_ni, cmd.load_out, status.out_free, "result overwritten")
  // Block is busy right after taking a transaction
  `MMCPQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  // Output valid rises only from a controller load
  `MMCPQ_ASSERT_NOW(a_valid_from_load, clk_i, rst_ni, $rose(out_valid_o), $past(cmd.load_out), "spurious result")

endmodule
